>>> hdl/tiny_accumulator_cpu_step_macros.svh
// assertion macros for the accumulator step block
`ifndef TINY_ACCUMULATOR_CPU_STEP_MACROS_SVH
`define TINY_ACCUMULATOR_CPU_STEP_MACROS_SVH

`ifndef SYNTHESIS

`define TACS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tacs: implication check failed");

`define TACS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tacs: next-cycle check failed");

`else

`define TACS_ASSERT_IMP(label, ante, cons)

`define TACS_ASSERT_NXT(label, ante, cons)

`endif

`endif

>>> hdl/tacs_pkg.sv
`default_nettype none

package tacs_pkg;

    localparam int ADDR_W = 16;
    localparam int BYTE_W = 8;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_READ   = 2'd1,
        ACT_SET_PC = 2'd2,
        ACT_EXEC   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_HALT   = 2'd1,
        ST_PC_OUT = 2'd2,
        ST_BAD_OP = 2'd3
    } status_t;

    localparam logic [7:0] OP_LOAD  = 8'h50;
    localparam logic [7:0] OP_STORE = 8'h51;
    localparam logic [7:0] OP_ADD   = 8'h5A;
    localparam logic [7:0] OP_SUB   = 8'h5B;
    localparam logic [7:0] OP_JUMP  = 8'h6E;
    localparam logic [7:0] OP_BEQ   = 8'h70;
    localparam logic [7:0] OP_HALT  = 8'hFF;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_OP,
        S_B1,
        S_B2,
        S_B3,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

>>> hdl/tacs_if.sv
`default_nettype none

interface tacs_cmd_if import tacs_pkg::*;;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] data;

    modport source (output valid, action, address, data, input ready);
    modport sink   (input valid, action, address, data, output ready);
endinterface

interface tacs_rsp_if import tacs_pkg::*;;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [ADDR_W-1:0] pc_now;
    logic [BYTE_W-1:0] w_now;
    logic [BYTE_W-1:0] read_data;
    logic              screen_changed;
    logic [ADDR_W-1:0] screen_address;

    modport source (output valid, status, pc_now, w_now, read_data, screen_changed,
                    screen_address, input ready);
    modport sink   (input valid, status, pc_now, w_now, read_data, screen_changed,
                    screen_address, output ready);
endinterface

`default_nettype wire

>>> hdl/tiny_accumulator_cpu_step.sv
// one item in flight in the sequencer, one waiting in the input register, one result
// held in the output register; all reads go through the single read port of the byte memory.
// reset: pc and w cleared, then a clearing pass writes zero to every byte,
// with cmd.ready low during the pass.
`default_nettype none
`include "tiny_accumulator_cpu_step_macros.svh"

module tiny_accumulator_cpu_step import tacs_pkg::*; #(
    parameter int MEMORY_BYTES = 1536,
    parameter int VIDEO_BYTES  = 1000
) (
    input  logic        clk,
    input  logic        rst_n,
    tacs_cmd_if.sink    cmd,
    tacs_rsp_if.source  rsp
);

    localparam int          AW        = $clog2(MEMORY_BYTES);
    localparam logic [16:0] MEM_LIMIT = 17'(MEMORY_BYTES);
    localparam logic [16:0] VID_LIMIT = 17'(VIDEO_BYTES);
    localparam logic [AW-1:0] CLR_LAST = AW'(MEMORY_BYTES - 1);

    logic [7:0] mem [MEMORY_BYTES];

    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_cnt_reg;

    logic            ibuf_valid_reg;
    action_t         ibuf_action_reg;
    logic [15:0]     ibuf_addr_reg;
    logic [7:0]      ibuf_data_reg;

    logic [15:0]     pc_reg, pc_next;
    logic [7:0]      w_reg, w_next;
    logic [7:0]      op_reg, op_next;
    logic [7:0]      hi_reg, hi_next;

    status_t         res_status_reg, res_status_next;
    logic [7:0]      res_read_reg, res_read_next;
    logic            res_scr_reg, res_scr_next;
    logic [15:0]     res_scr_addr_reg, res_scr_addr_next;

    logic            out_valid_reg;
    status_t         out_status_reg;
    logic [15:0]     out_pc_reg;
    logic [7:0]      out_w_reg;
    logic [7:0]      out_read_reg;
    logic            out_scr_reg;
    logic [15:0]     out_scr_addr_reg;

    logic [7:0]      mem_q_reg;
    logic            rd_oob_reg;

    logic [16:0]     rd_addr;
    logic            rd_oob;
    logic [AW-1:0]   rd_idx;
    logic            wr_req;
    logic [16:0]     wr_addr;
    logic [7:0]      wr_dat;
    logic            wr_hit;
    logic            mem_wr_en;
    logic [AW-1:0]   mem_wr_idx;
    logic [7:0]      mem_wr_dat;

    logic [7:0]      rdat;
    logic            out_free;
    logic            cmd_acc;
    logic            pc_in_mem;
    logic [16:0]     pc_p1, pc_p2, pc_p3;

    assign rdat      = rd_oob_reg ? 8'h00 : mem_q_reg;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign cmd.ready = !ibuf_valid_reg && (state_reg != S_CLEAR);
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign pc_in_mem = {1'b0, pc_reg} < MEM_LIMIT;
    assign pc_p1     = {1'b0, pc_reg} + 17'd1;
    assign pc_p2     = {1'b0, pc_reg} + 17'd2;
    assign pc_p3     = {1'b0, pc_reg} + 17'd3;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (ibuf_valid_reg)
                begin
                    case (ibuf_action_reg)
                        ACT_READ: state_next = S_READ;
                        ACT_EXEC: state_next = pc_in_mem ? S_OP : S_DONE;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_READ: state_next = S_DONE;
            S_OP:
            begin
                if (rdat inside {OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_JUMP, OP_BEQ})
                    state_next = S_B1;
                else
                    state_next = S_DONE;
            end
            S_B1:
            begin
                if (op_reg inside {OP_STORE, OP_JUMP})
                    state_next = S_B2;
                else if (op_reg == OP_BEQ && rdat == w_reg)
                    state_next = S_B2;
                else
                    state_next = S_DONE;
            end
            S_B2: state_next = (op_reg == OP_BEQ) ? S_B3 : S_DONE;
            S_B3: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory access per state
    always_comb
    begin
        rd_addr           = {1'b0, pc_reg};
        wr_req            = 1'b0;
        wr_addr           = {1'b0, ibuf_addr_reg};
        wr_dat            = ibuf_data_reg;
        pc_next           = pc_reg;
        w_next            = w_reg;
        op_next           = op_reg;
        hi_next           = hi_reg;
        res_status_next   = res_status_reg;
        res_read_next     = res_read_reg;
        res_scr_next      = res_scr_reg;
        res_scr_addr_next = res_scr_addr_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (ibuf_valid_reg)
                begin
                    res_status_next   = ST_OK;
                    res_read_next     = 8'h00;
                    res_scr_next      = 1'b0;
                    res_scr_addr_next = 16'h0000;
                    case (ibuf_action_reg)
                        ACT_WRITE:  wr_req = 1'b1;
                        ACT_READ:   rd_addr = {1'b0, ibuf_addr_reg};
                        ACT_SET_PC: pc_next = ibuf_addr_reg;
                        default:
                        begin
                            if (!pc_in_mem)
                                res_status_next = ST_PC_OUT;
                        end
                    endcase
                end
            end
            S_READ: res_read_next = rdat;
            S_OP:
            begin
                rd_addr = pc_p1;
                op_next = rdat;
                if (rdat == OP_HALT)
                    res_status_next = ST_HALT;
                else if (!(rdat inside {OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_JUMP,
                                        OP_BEQ}))
                    res_status_next = ST_BAD_OP;
            end
            S_B1:
            begin
                rd_addr = pc_p2;
                hi_next = rdat;
                case (op_reg)
                    OP_LOAD:
                    begin
                        w_next  = rdat;
                        pc_next = pc_reg + 16'd2;
                    end
                    OP_ADD:
                    begin
                        w_next  = w_reg + rdat;
                        pc_next = pc_reg + 16'd2;
                    end
                    OP_SUB:
                    begin
                        w_next  = w_reg - rdat;
                        pc_next = pc_reg + 16'd2;
                    end
                    OP_BEQ:
                    begin
                        if (rdat != w_reg)
                            pc_next = pc_reg + 16'd4;
                    end
                    default: ;
                endcase
            end
            S_B2:
            begin
                rd_addr = pc_p3;
                case (op_reg)
                    OP_STORE:
                    begin
                        wr_req  = 1'b1;
                        wr_addr = {1'b0, hi_reg, rdat};
                        wr_dat  = w_reg;
                        pc_next = pc_reg + 16'd3;
                    end
                    OP_JUMP: pc_next = {hi_reg, rdat};
                    default: hi_next = rdat;
                endcase
            end
            S_B3: pc_next = {hi_reg, rdat};
            default: ;
        endcase
        if (wr_req && (wr_addr < MEM_LIMIT) && (wr_addr < VID_LIMIT))
        begin
            res_scr_next      = 1'b1;
            res_scr_addr_next = wr_addr[15:0];
        end
    end

    assign wr_hit  = wr_req && (wr_addr < MEM_LIMIT);
    assign rd_oob  = rd_addr >= MEM_LIMIT;
    assign rd_idx  = rd_oob ? '0 : rd_addr[AW-1:0];

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            mem_wr_en  = 1'b1;
            mem_wr_idx = clr_cnt_reg;
            mem_wr_dat = 8'h00;
        end
        else
        begin
            mem_wr_en  = wr_hit;
            mem_wr_idx = wr_addr[AW-1:0];
            mem_wr_dat = wr_dat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
            mem[mem_wr_idx] <= mem_wr_dat;
    end

    always_ff @(posedge clk)
    begin
        mem_q_reg <= mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            ibuf_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            pc_reg         <= 16'h0000;
            w_reg          <= 8'h00;
            rd_oob_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            w_reg      <= w_next;
            rd_oob_reg <= rd_oob;
            if (state_reg == S_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (cmd_acc)
                ibuf_valid_reg <= 1'b1;
            else if (state_reg == S_IDLE)
                ibuf_valid_reg <= 1'b0;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            ibuf_action_reg <= action_t'(cmd.action);
            ibuf_addr_reg   <= cmd.address;
            ibuf_data_reg   <= cmd.data;
        end
        op_reg           <= op_next;
        hi_reg           <= hi_next;
        res_status_reg   <= res_status_next;
        res_read_reg     <= res_read_next;
        res_scr_reg      <= res_scr_next;
        res_scr_addr_reg <= res_scr_addr_next;
        if (state_reg == S_DONE && out_free)
        begin
            out_status_reg   <= res_status_reg;
            out_pc_reg       <= pc_reg;
            out_w_reg        <= w_reg;
            out_read_reg     <= res_read_reg;
            out_scr_reg      <= res_scr_reg;
            out_scr_addr_reg <= res_scr_addr_reg;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.pc_now         = out_pc_reg;
    assign rsp.w_now          = out_w_reg;
    assign rsp.read_data      = out_read_reg;
    assign rsp.screen_changed = out_scr_reg;
    assign rsp.screen_address = out_scr_addr_reg;

    `TACS_ASSERT_IMP(a_scr_in_video, rsp.valid && rsp.screen_changed, 17'(rsp.screen_address) < VID_LIMIT)
    `TACS_ASSERT_IMP(a_fault_no_side, rsp.valid && rsp.status != ST_OK, !rsp.screen_changed && rsp.read_data == 8'h00)
    `TACS_ASSERT_NXT(a_done_to_out, state_reg == S_DONE && out_free, out_valid_reg && state_reg == S_IDLE)

endmodule

`default_nettype wire
